// ===== hdl/fpf_pkg.sv =====
// ---------------------------------------------------------------------------
// fpf_pkg: shared types and constants for the pixel fill block
// Field widths, operation codes and the beat types of the request and
// response channels, plus the command groups between the internal units.
// ---------------------------------------------------------------------------
`default_nettype none

package fpf_pkg;

   // fixed field widths
   localparam int CfgW    = 7;
   localparam int CoordW  = 6;
   localparam int ColorW  = 24;
   localparam int ByteW   = 8;
   localparam int CsrIdxW = 1;
   localparam int LaneW   = 2;
   // compare width for canvas registers against size limits up to 1024
   localparam int CmpW    = 11;
   // padded row stride of a canvas of up to 127 pixels
   localparam int StrideW = 9;
   // stride * row + 3 * col before fitting to the address width
   localparam int CalcW   = 17;

   localparam int DefMaxWidth  = 64;
   localparam int DefMaxHeight = 64;

   localparam logic [CfgW-1:0] CanvasReset = 7'd64;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_CANVAS_WIDTH  = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_CANVAS_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_FILL  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_X_RANGE = 2'd1,
      STATUS_Y_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic [CoordW-1:0]  x;
      logic [CoordW-1:0]  y;
      logic [CfgW-1:0]    rect_width;
      logic [CfgW-1:0]    rect_height;
      logic [ColorW-1:0]  color;
   } fpf_req_type;

   typedef struct packed {
      logic [ColorW-1:0]  read_color;
      status_type         status;
   } fpf_rsp_type;

   // address unit command: load a pixel base or step one byte
   typedef struct packed {
      logic               load;
      logic               inc;
      logic [CfgW-1:0]    col;
      logic [CfgW-1:0]    row;
      logic [StrideW-1:0] stride;
   } fpf_addr_cmd_type;

   // byte store command, the address travels beside it
   typedef struct packed {
      logic               we;
      logic [ByteW-1:0]   wdata;
   } fpf_mem_cmd_type;

endpackage

`default_nettype wire

// ===== hdl/fpf_store.sv =====
// ---------------------------------------------------------------------------
// fpf_store: byte-wide pixel store
// One port: a byte is written or read at the given address each cycle,
// read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module fpf_store
   import fpf_pkg::*;
#(
   parameter int StoreBytes = 12288,
   parameter int AddrW      = 14
) (
   input  logic                 clock,
   input  fpf_mem_cmd_type      cmd,
   input  logic [AddrW-1:0]     addr,
   output logic [ByteW-1:0]     rdata
);

   logic [ByteW-1:0] mem [StoreBytes];
   logic [ByteW-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[addr] <= cmd.wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/fpf_addr.sv =====
// ---------------------------------------------------------------------------
// fpf_addr: shared byte address unit
// Loads stride * row + 3 * col for a pixel's first byte, or steps the
// held address by one byte; used by reads, writes, fills and the clear.
// ---------------------------------------------------------------------------
`default_nettype none

module fpf_addr
   import fpf_pkg::*;
#(
   parameter int AddrW = 14
) (
   input  logic              clock,
   input  fpf_addr_cmd_type  cmd,
   output logic [AddrW-1:0]  addr
);

   localparam int SumW = (AddrW > CalcW) ? AddrW : CalcW;

   logic [CalcW-1:0] prod;
   logic [SumW-1:0]  base;
   logic [AddrW-1:0] addr_ff;
   logic [AddrW-1:0] addr_in;

   // row offset from the bottom of the store plus three bytes per column
   always_comb begin
      prod = CalcW'(cmd.stride) * CalcW'(cmd.row);
      base = SumW'(prod) + SumW'({cmd.col, 1'b0}) + SumW'(cmd.col);
   end

   // load, step or hold
   always_comb begin
      if (cmd.load) begin
         addr_in = base[AddrW-1:0];
      end else if (cmd.inc) begin
         addr_in = addr_ff + AddrW'(1);
      end else begin
         addr_in = addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign addr = addr_ff;

endmodule

`default_nettype wire

// ===== hdl/framebuffer_pixel_fill.sv =====
// ---------------------------------------------------------------------------
// framebuffer_pixel_fill: 24-bit bottom-up pixel store with rectangle fill
// Byte-wide store in B,G,R order with rows padded to four bytes, driven by
// a sequencer around one shared address unit.
// ---------------------------------------------------------------------------
// After reset the block clears the whole store, one byte per cycle (12288
// bytes with the default 64 x 64 limits), and holds req_stall high
// meanwhile; configuration writes are taken at any time. Every item is
// handled alone and the store's single byte port sets the pace: a range
// error or an unused mode goes straight to the response register, a pixel
// write loads the address and then writes three bytes, a pixel read loads
// the address and then reads three registered bytes, and a fill writes
// three bytes for each pixel of the rectangle after clipping. A new
// request is taken while the previous response still waits in its register.
`default_nettype none

module framebuffer_pixel_fill
   import fpf_pkg::*;
#(
   parameter int MAX_WIDTH  = DefMaxWidth,
   parameter int MAX_HEIGHT = DefMaxHeight
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  fpf_req_type         req_data,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fpf_rsp_type         rsp_data,
   // register write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CfgW-1:0]     csr_wdata
);

   localparam int MaxStride  = ((MAX_WIDTH * 3 + 3) / 4) * 4;
   localparam int StoreBytes = MaxStride * MAX_HEIGHT;
   localparam int AddrW      = $clog2(StoreBytes);

   typedef enum logic [2:0] {
      ST_CLR_INIT,
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DONE
   } state_type;

   // configuration
   logic [CfgW-1:0]    cfg_w_ff, cfg_w_in;
   logic [CfgW-1:0]    cfg_h_ff, cfg_h_in;
   logic [CfgW-1:0]    w_eff, h_eff;
   logic [StrideW-1:0] stride_raw, stride;

   // sequencer
   state_type          state_ff, state_in;
   fpf_req_type        item_ff, item_in;
   logic [CfgW-1:0]    col_ff, col_in;
   logic [CfgW:0]      col_end_ff, col_end_in;
   logic [CfgW-1:0]    row_ff, row_in;
   logic [CfgW:0]      row_end_ff, row_end_in;
   logic [LaneW-1:0]   lane_ff, lane_in;
   logic [ColorW-1:0]  acc_ff, acc_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   fpf_rsp_type        rsp_data_ff, rsp_data_in;

   // request decode
   logic               accept;
   logic [CfgW-1:0]    x_ext, y_ext;
   logic               x_bad, y_bad;
   logic [CfgW:0]      xe_sum, ye_sum, col_lim, row_lim;
   logic [CfgW:0]      col_next, row_next;

   // unit connections
   fpf_addr_cmd_type   addr_cmd;
   fpf_mem_cmd_type    mem_cmd;
   logic [AddrW-1:0]   addr;
   logic [ByteW-1:0]   rdata;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_w_in = cfg_w_ff;
      cfg_h_in = cfg_h_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  cfg_w_in = csr_wdata;
            CSR_CANVAS_HEIGHT: cfg_h_in = csr_wdata;
            default:           cfg_w_in = cfg_w_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= CanvasReset;
         cfg_h_ff <= CanvasReset;
      end else begin
         cfg_w_ff <= cfg_w_in;
         cfg_h_ff <= cfg_h_in;
      end
   end

   // canvas size limited to the store, padded stride
   always_comb begin
      w_eff = (CmpW'(cfg_w_ff) > CmpW'(MAX_WIDTH))  ? CfgW'(MAX_WIDTH)  : cfg_w_ff;
      h_eff = (CmpW'(cfg_h_ff) > CmpW'(MAX_HEIGHT)) ? CfgW'(MAX_HEIGHT) : cfg_h_ff;
      stride_raw = StrideW'(w_eff) * StrideW'(3) + StrideW'(3);
      stride = {stride_raw[StrideW-1:2], 2'b00};
   end

   // request range checks and clipped fill limits
   always_comb begin
      accept   = req_valid && !req_stall;
      x_ext    = CfgW'(req_data.x);
      y_ext    = CfgW'(req_data.y);
      x_bad    = x_ext >= w_eff;
      y_bad    = y_ext >= h_eff;
      xe_sum   = (CfgW+1)'(x_ext) + (CfgW+1)'(req_data.rect_width);
      ye_sum   = (CfgW+1)'(y_ext) + (CfgW+1)'(req_data.rect_height);
      col_lim  = (xe_sum > (CfgW+1)'(w_eff)) ? (CfgW+1)'(w_eff) : xe_sum;
      row_lim  = (ye_sum > (CfgW+1)'(h_eff)) ? (CfgW+1)'(h_eff) : ye_sum;
      col_next = (CfgW+1)'(col_ff) + (CfgW+1)'(1);
      row_next = (CfgW+1)'(row_ff) + (CfgW+1)'(1);
   end

   assign req_stall = (state_ff != ST_IDLE);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      col_in       = col_ff;
      col_end_in   = col_end_ff;
      row_in       = row_ff;
      row_end_in   = row_end_ff;
      lane_in      = lane_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      addr_cmd.load   = 1'b0;
      addr_cmd.inc    = 1'b0;
      addr_cmd.col    = col_ff;
      addr_cmd.row    = h_eff - row_ff - CfgW'(1);
      addr_cmd.stride = stride;

      mem_cmd.we    = 1'b0;
      mem_cmd.wdata = '0;

      // response beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLR_INIT: begin
            addr_cmd.load = 1'b1;
            addr_cmd.col  = '0;
            addr_cmd.row  = '0;
            state_in      = ST_CLEAR;
         end

         ST_CLEAR: begin
            mem_cmd.we   = 1'b1;
            addr_cmd.inc = 1'b1;
            if (addr == AddrW'(StoreBytes - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               item_in    = req_data;
               acc_in     = '0;
               status_in  = STATUS_OK;
               lane_in    = '0;
               col_in     = x_ext;
               row_in     = y_ext;
               col_end_in = (CfgW+1)'(x_ext) + (CfgW+1)'(1);
               row_end_in = (CfgW+1)'(y_ext) + (CfgW+1)'(1);
               addr_cmd.col = x_ext;
               addr_cmd.row = h_eff - y_ext - CfgW'(1);
               state_in   = ST_DONE;
               unique case (req_data.mode) inside
                  MODE_READ, MODE_WRITE: begin
                     if (x_bad) begin
                        status_in = STATUS_X_RANGE;
                     end else if (y_bad) begin
                        status_in = STATUS_Y_RANGE;
                     end else begin
                        addr_cmd.load = 1'b1;
                        state_in = (req_data.mode == MODE_READ) ? ST_READ : ST_WRITE;
                     end
                  end
                  MODE_FILL: begin
                     if (!x_bad && !y_bad && (req_data.rect_width != '0) &&
                         (req_data.rect_height != '0)) begin
                        addr_cmd.load = 1'b1;
                        col_end_in    = col_lim;
                        row_end_in    = row_lim;
                        state_in      = ST_WRITE;
                     end
                  end
                  MODE_NOP: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_WRITE: begin
            // one byte per cycle, blue first
            mem_cmd.we = 1'b1;
            case (lane_ff)
               2'd0:    mem_cmd.wdata = item_ff.color[7:0];
               2'd1:    mem_cmd.wdata = item_ff.color[15:8];
               2'd2:    mem_cmd.wdata = item_ff.color[23:16];
               default: mem_cmd.wdata = '0;
            endcase
            if (lane_ff != 2'd2) begin
               addr_cmd.inc = 1'b1;
               lane_in      = lane_ff + LaneW'(1);
            end else begin
               lane_in = '0;
               if (col_next != col_end_ff) begin
                  // next pixel of the row follows directly
                  addr_cmd.inc = 1'b1;
                  col_in       = col_next[CfgW-1:0];
               end else if (row_next != row_end_ff) begin
                  // next row: reload the base for the left edge
                  addr_cmd.load = 1'b1;
                  addr_cmd.col  = CfgW'(item_ff.x);
                  addr_cmd.row  = h_eff - row_next[CfgW-1:0] - CfgW'(1);
                  col_in        = CfgW'(item_ff.x);
                  row_in        = row_next[CfgW-1:0];
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_READ: begin
            // read data arrives in the cycle after its address
            addr_cmd.inc = 1'b1;
            lane_in      = lane_ff + LaneW'(1);
            case (lane_ff)
               2'd1:    acc_in[7:0]   = rdata;
               2'd2:    acc_in[15:8]  = rdata;
               2'd3: begin
                  acc_in[23:16] = rdata;
                  state_in      = ST_DONE;
               end
               default: acc_in = acc_ff;
            endcase
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.read_color = acc_ff;
               rsp_data_in.status     = status_ff;
               state_in               = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         item_ff      <= item_in;
         col_ff       <= col_in;
         col_end_ff   <= col_end_in;
         row_ff       <= row_in;
         row_end_ff   <= row_end_in;
         lane_ff      <= lane_in;
         acc_ff       <= acc_in;
         status_ff    <= status_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // shared address unit
   fpf_addr #(
      .AddrW (AddrW)
   ) u_addr (
      .clock (clock),
      .cmd   (addr_cmd),
      .addr  (addr)
   );

   // byte store
   fpf_store #(
      .StoreBytes (StoreBytes),
      .AddrW      (AddrW)
   ) u_store (
      .clock (clock),
      .cmd   (mem_cmd),
      .addr  (addr),
      .rdata (rdata)
   );

endmodule

`default_nettype wire

// ===== hdl/fpf_checker.sv =====
// ---------------------------------------------------------------------------
// fpf_checker: port-level checks for the pixel fill block
// Watches the top level's ports and is bound to every instance of it.
// ---------------------------------------------------------------------------
`default_nettype none

module fpf_checker
   import fpf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  fpf_rsp_type         rsp_data
);

   // the store clear holds off requests, no response is pending after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("request taken or response shown right after reset");

   // one item at a time: an accepted beat closes the request side
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side open the cycle after an accepted beat");

   // an error response carries no colour
   a_error_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_OK)) |-> (rsp_data.read_color == '0))
      else $error("range error response with nonzero colour");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response beat changed");

endmodule

bind framebuffer_pixel_fill fpf_checker u_fpf_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: pixel read, write and rectangle fill on the BMP-style store
// Drives request beats through the valid/stall channel and changes canvas
// size between phases. A shadow byte store with the same bottom-up, padded
// layout predicts each response, which is checked in order as it comes out.
// ---------------------------------------------------------------------------

// shadow copy of the pixel store and the canvas registers
class fill_scoreboard;
   localparam int MaxStride  = (fpf_pkg::DefMaxWidth * 3 + 3) / 4 * 4;
   localparam int StoreBytes = MaxStride * fpf_pkg::DefMaxHeight;

   logic [fpf_pkg::ByteW-1:0] shadow_bytes [StoreBytes];
   int                        canvas_w;
   int                        canvas_h;
   fpf_pkg::fpf_rsp_type      pending_rsp [$];
   int                        failures;

   function new();
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      canvas_w  = fpf_pkg::CanvasReset;
      canvas_h  = fpf_pkg::CanvasReset;
      failures  = 0;
   endfunction

   function void write_register(logic [fpf_pkg::CsrIdxW-1:0] idx, int value);
      if (idx == fpf_pkg::CSR_CANVAS_WIDTH) canvas_w = value & 'h7f;
      else canvas_h = value & 'h7f;
   endfunction

   // oversized registers are clamped to the store limits
   function int eff_width();
      return (canvas_w > fpf_pkg::DefMaxWidth) ? fpf_pkg::DefMaxWidth : canvas_w;
   endfunction

   function int eff_height();
      return (canvas_h > fpf_pkg::DefMaxHeight) ? fpf_pkg::DefMaxHeight : canvas_h;
   endfunction

   function int pending();
      return pending_rsp.size();
   endfunction

   // first byte of a pixel: rows bottom-up, stride padded to four bytes
   function int pixel_base(int px, int py);
      int stride;
      stride = (eff_width() * 3 + 3) / 4 * 4;
      return stride * (eff_height() - 1 - py) + px * 3;
   endfunction

   function void store_pixel(int px, int py, logic [fpf_pkg::ColorW-1:0] rgb);
      int base;
      base = pixel_base(px, py);
      if (base + 2 < StoreBytes) begin
         shadow_bytes[base]     = rgb[7:0];
         shadow_bytes[base + 1] = rgb[15:8];
         shadow_bytes[base + 2] = rgb[23:16];
      end
   endfunction

   function logic [fpf_pkg::ColorW-1:0] load_pixel(int px, int py);
      int base;
      base = pixel_base(px, py);
      if (base + 2 >= StoreBytes) return '0;
      return {shadow_bytes[base + 2], shadow_bytes[base + 1], shadow_bytes[base]};
   endfunction

   // work out the response of one accepted request beat
   function void note_request(fpf_pkg::fpf_req_type req);
      fpf_pkg::fpf_rsp_type rsp;
      int w, h, px, py, col_end, row_end;
      w = eff_width();
      h = eff_height();
      px = req.x;
      py = req.y;
      rsp.read_color = '0;
      rsp.status = fpf_pkg::STATUS_OK;
      case (req.mode)
         fpf_pkg::MODE_READ, fpf_pkg::MODE_WRITE: begin
            // x is checked before y
            if (px >= w) rsp.status = fpf_pkg::STATUS_X_RANGE;
            else if (py >= h) rsp.status = fpf_pkg::STATUS_Y_RANGE;
            else if (req.mode == fpf_pkg::MODE_READ) rsp.read_color = load_pixel(px, py);
            else store_pixel(px, py, req.color);
         end
         fpf_pkg::MODE_FILL: begin
            // clipped fill, nothing when the origin is off the canvas
            if (px < w && py < h) begin
               col_end = px + int'(req.rect_width);
               row_end = py + int'(req.rect_height);
               if (col_end > w) col_end = w;
               if (row_end > h) row_end = h;
               for (int u = px; u < col_end; u++)
                  for (int v = py; v < row_end; v++)
                     store_pixel(u, v, req.color);
            end
         end
         default: ;
      endcase
      pending_rsp.push_back(rsp);
   endfunction

   function void check_response(fpf_pkg::fpf_rsp_type got);
      fpf_pkg::fpf_rsp_type want;
      if (pending_rsp.size() == 0) begin
         $error("response beat with nothing outstanding: read_color %h status %0d",
                got.read_color, got.status);
         failures++;
         return;
      end
      want = pending_rsp.pop_front();
      if (got.read_color !== want.read_color) begin
         $error("read_color: expected %h, actual %h", want.read_color, got.read_color);
         failures++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         failures++;
      end
   endfunction
endclass

module testbench;
   import fpf_pkg::*;

   localparam int NumPhases = 9;
   localparam int HoldPhase = 4;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   fpf_req_type         req_data    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   fpf_rsp_type         rsp_data;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index   = CSR_CANVAS_WIDTH;
   logic [CfgW-1:0]     csr_wdata   = '0;

   fill_scoreboard      sb;
   bit                  idle_on        = 1'b0;
   bit                  want_long_hold = 1'b0;
   logic [CoordW-1:0]   last_x         = '0;
   logic [CoordW-1:0]   last_y         = '0;

   // canvas size and length of each random phase, extremes included
   int phase_w     [NumPhases] = '{64, 1, 1, 64, 127, 13, 0, 33, 64};
   int phase_h     [NumPhases] = '{64, 1, 64, 1, 90, 29, 20, 64, 64};
   int phase_items [NumPhases] = '{150, 60, 80, 80, 150, 150, 30, 150, 200};

   framebuffer_pixel_fill DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #60_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic fpf_req_type make_item(mode_type m, int px, int py, int rw, int rh,
                                             logic [ColorW-1:0] rgb);
      fpf_req_type item;
      item.mode        = m;
      item.x           = CoordW'(px);
      item.y           = CoordW'(py);
      item.rect_width  = CfgW'(rw);
      item.rect_height = CfgW'(rh);
      item.color       = rgb;
      return item;
   endfunction

   // mostly on-canvas coordinates, reads often revisit the last written pixel
   function automatic fpf_req_type random_item();
      fpf_req_type item;
      int w, h, pick;
      w = sb.eff_width();
      h = sb.eff_height();
      pick = $urandom_range(0, 99);
      if (pick < 34) item.mode = MODE_READ;
      else if (pick < 68) item.mode = MODE_WRITE;
      else if (pick < 92) item.mode = MODE_FILL;
      else item.mode = MODE_NOP;
      if (w > 0 && $urandom_range(0, 9) < 8) item.x = CoordW'($urandom_range(0, w - 1));
      else item.x = CoordW'($urandom);
      if (h > 0 && $urandom_range(0, 9) < 8) item.y = CoordW'($urandom_range(0, h - 1));
      else item.y = CoordW'($urandom);
      if (item.mode == MODE_READ && $urandom_range(0, 9) < 4) begin
         item.x = last_x;
         item.y = last_y;
      end
      item.rect_width  = CfgW'($urandom);
      item.rect_height = CfgW'($urandom);
      // keep most fills small, the odd one takes a random size and is clipped
      if (item.mode == MODE_FILL && $urandom_range(0, 11) != 0) begin
         item.rect_width  = CfgW'($urandom_range(0, 6));
         item.rect_height = CfgW'($urandom_range(0, 6));
      end
      item.color = ColorW'($urandom);
      if (item.mode == MODE_WRITE || item.mode == MODE_FILL) begin
         last_x = item.x;
         last_y = item.y;
      end
      return item;
   endfunction

   // present one request beat and hold it until taken; valid stays high
   task automatic send_item(input fpf_req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(item);
   endtask

   // stop sending and wait for every outstanding response
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic set_canvas(input int width, input int height);
      csr_valid <= 1'b1;
      csr_index <= CSR_CANVAS_WIDTH;
      csr_wdata <= CfgW'(width);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(CSR_CANVAS_WIDTH, width);
      csr_index <= CSR_CANVAS_HEIGHT;
      csr_wdata <= CfgW'(height);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(CSR_CANVAS_HEIGHT, height);
      csr_valid <= 1'b0;
   endtask

   // response side: random stall bursts, one long hold-off on request
   initial begin
      int stall_left;
      int run_left;
      bit long_hold_done;
      stall_left = 0;
      run_left = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (want_long_hold && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left = 300;
            run_left = 0;
         end else if (stall_left == 0 && run_left == 0) begin
            if (idle_on && $urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 11);
            else run_left = $urandom_range(1, 30);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (run_left > 0) run_left--;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, empty and clipped fills, unused mode
      set_canvas(64, 64);
      send_item(make_item(MODE_READ, 0, 0, 0, 0, 24'h000000));
      send_item(make_item(MODE_WRITE, 0, 0, 0, 0, 24'hffffff));
      send_item(make_item(MODE_READ, 0, 0, 0, 0, 24'h000000));
      send_item(make_item(MODE_WRITE, 63, 63, 0, 0, 24'ha5c3e1));
      send_item(make_item(MODE_READ, 63, 63, 0, 0, 24'h000000));
      send_item(make_item(MODE_WRITE, 63, 0, 0, 0, 24'h123456));
      send_item(make_item(MODE_READ, 0, 63, 0, 0, 24'h000000));
      send_item(make_item(MODE_FILL, 0, 0, 0, 5, 24'h777777));
      send_item(make_item(MODE_FILL, 0, 0, 5, 0, 24'h777777));
      send_item(make_item(MODE_READ, 0, 0, 0, 0, 24'h000000));
      send_item(make_item(MODE_FILL, 60, 60, 127, 127, 24'h00ff00));
      send_item(make_item(MODE_READ, 63, 63, 0, 0, 24'h000000));
      send_item(make_item(MODE_NOP, 63, 63, 127, 127, 24'hffffff));
      send_item(make_item(MODE_READ, 63, 63, 0, 0, 24'h000000));
      send_item(make_item(MODE_FILL, 0, 0, 64, 64, 24'h000000));

      // range errors on a small canvas, x reported before y
      settle();
      set_canvas(10, 7);
      send_item(make_item(MODE_WRITE, 10, 3, 0, 0, 24'h111111));
      send_item(make_item(MODE_READ, 4, 7, 0, 0, 24'h000000));
      send_item(make_item(MODE_WRITE, 10, 7, 0, 0, 24'h222222));
      send_item(make_item(MODE_FILL, 12, 1, 8, 8, 24'h333333));
      send_item(make_item(MODE_FILL, 3, 2, 64, 64, 24'hc0ffee));
      send_item(make_item(MODE_READ, 9, 6, 0, 0, 24'h000000));
      send_item(make_item(MODE_READ, 2, 1, 0, 0, 24'h000000));

      // empty canvas, then oversized registers reread the old bytes
      settle();
      set_canvas(0, 0);
      send_item(make_item(MODE_READ, 0, 0, 0, 0, 24'h000000));
      send_item(make_item(MODE_FILL, 0, 0, 5, 5, 24'h444444));
      settle();
      set_canvas(127, 127);
      send_item(make_item(MODE_READ, 3, 0, 0, 0, 24'h000000));

      // random phases, the last one without idling
      for (int p = 0; p < NumPhases; p++) begin
         settle();
         set_canvas(phase_w[p], phase_h[p]);
         idle_on = (p != NumPhases - 1);
         for (int i = 0; i < phase_items[p]; i++) begin
            if (p == HoldPhase && i == 50) want_long_hold = 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 11)) @(posedge clock);
            end
            send_item(random_item());
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
